[design/fbc_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// fbc_pkg
// Shared types, constants and round functions of the 64-bit Feistel cipher.
// ============================================================================
package fbc_pkg;

   localparam int unsigned ROUNDS     = 32;
   localparam int unsigned HALF_W     = 32;
   localparam int unsigned BLOCK_W    = 64;
   localparam int unsigned NUM_KEYS   = 8;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned ROT_AMOUNT = 11;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_0_1 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_2_3 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_4_5 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_6_7 = 2'd3;

   localparam logic FUNC_ENCRYPT = 1'b0;
   localparam logic FUNC_DECRYPT = 1'b1;

   typedef logic [NUM_KEYS-1:0][HALF_W-1:0] fbc_keys_type;

   // One pipeline slot: the word in flight and its control.
   typedef struct packed {
      logic              valid;
      logic              func;
      logic [HALF_W-1:0] n1;
      logic [HALF_W-1:0] n2;
   } fbc_stage_type;

   localparam logic [3:0] SBOX [8][16] = '{
      '{4'hF, 4'hC, 4'h2, 4'hA, 4'h6, 4'h4, 4'h5, 4'h0,
        4'h7, 4'h9, 4'hE, 4'hD, 4'h1, 4'hB, 4'h8, 4'h3},
      '{4'hB, 4'h6, 4'h3, 4'h4, 4'hC, 4'hF, 4'hE, 4'h2,
        4'h7, 4'hD, 4'h8, 4'h0, 4'h5, 4'hA, 4'h9, 4'h1},
      '{4'h1, 4'hC, 4'hB, 4'h0, 4'hF, 4'hE, 4'h6, 4'h5,
        4'hA, 4'hD, 4'h4, 4'h8, 4'h9, 4'h3, 4'h7, 4'h2},
      '{4'h1, 4'h5, 4'hE, 4'hC, 4'hA, 4'h7, 4'h0, 4'hD,
        4'h6, 4'h2, 4'hB, 4'h4, 4'h9, 4'h3, 4'hF, 4'h8},
      '{4'h0, 4'hC, 4'h8, 4'h9, 4'hD, 4'h2, 4'hA, 4'hB,
        4'h7, 4'h3, 4'h6, 4'h5, 4'h4, 4'hE, 4'hF, 4'h1},
      '{4'h8, 4'h0, 4'hF, 4'h3, 4'h2, 4'h5, 4'hE, 4'hB,
        4'h1, 4'hA, 4'h4, 4'h7, 4'hC, 4'h9, 4'hD, 4'h6},
      '{4'h3, 4'h0, 4'h6, 4'hF, 4'h1, 4'hE, 4'h9, 4'h2,
        4'hD, 4'h8, 4'hC, 4'h4, 4'hB, 4'hA, 4'h5, 4'h7},
      '{4'h1, 4'hA, 4'h6, 4'h8, 4'hF, 4'hB, 4'h0, 4'h4,
        4'hC, 4'h3, 4'h5, 4'h9, 4'h7, 4'hD, 4'h2, 4'hE}
   };

   // Round function: add subkey, substitute each nibble through its own row,
   // rotate left.
   function automatic logic [HALF_W-1:0] round_func(input logic [HALF_W-1:0] half,
                                                    input logic [HALF_W-1:0] k);
      logic [HALF_W-1:0] t;
      logic [HALF_W-1:0] s;
      t = half + k;
      for (int j = 0; j < 8; j++) begin
         s[4*j +: 4] = SBOX[j][t[4*j +: 4]];
      end
      return {s[HALF_W-ROT_AMOUNT-1:0], s[HALF_W-1:HALF_W-ROT_AMOUNT]};
   endfunction

   // Subkey used in a given round. Encryption runs K0..K7 three times and then
   // K7..K0; decryption runs K0..K7 once and then K7..K0 three times.
   function automatic logic [2:0] key_index(input logic [4:0] r, input logic dec);
      logic fwd;
      fwd = dec ? (r < 5'd8) : (r < 5'd24);
      return fwd ? r[2:0] : ~r[2:0];
   endfunction

endpackage

[design/fbc_key_regs.sv]
`timescale 1ns / 1ps
// ============================================================================
// fbc_key_regs
// Configuration registers holding the eight 32-bit subkeys.
// ============================================================================
module fbc_key_regs (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fbc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fbc_pkg::BLOCK_W-1:0]   csr_data,
   output fbc_pkg::fbc_keys_type         keys
);
   import fbc_pkg::*;

   fbc_keys_type keys_ff;
   fbc_keys_type keys_in;

   assign csr_ready = ~reset;

   // The even subkey of a pair sits in the upper half of the written word.
   always_comb begin
      keys_in = keys_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_KEY_0_1: begin
               keys_in[0] = csr_data[BLOCK_W-1:HALF_W];
               keys_in[1] = csr_data[HALF_W-1:0];
            end
            CSR_KEY_2_3: begin
               keys_in[2] = csr_data[BLOCK_W-1:HALF_W];
               keys_in[3] = csr_data[HALF_W-1:0];
            end
            CSR_KEY_4_5: begin
               keys_in[4] = csr_data[BLOCK_W-1:HALF_W];
               keys_in[5] = csr_data[HALF_W-1:0];
            end
            CSR_KEY_6_7: begin
               keys_in[6] = csr_data[BLOCK_W-1:HALF_W];
               keys_in[7] = csr_data[HALF_W-1:0];
            end
            default: begin
               keys_in = keys_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff <= '0;
      end else begin
         keys_ff <= keys_in;
      end
   end

   assign keys = keys_ff;

endmodule

[design/fbc_round.sv]
`timescale 1ns / 1ps
// ============================================================================
// fbc_round
// One registered Feistel round of the cipher pipeline.
// ============================================================================
module fbc_round (
   input  logic                         clock,
   input  logic                         reset,
   input  fbc_pkg::fbc_stage_type       stage_in,
   input  logic [fbc_pkg::HALF_W-1:0]   subkey,
   output fbc_pkg::fbc_stage_type       stage_out
);
   import fbc_pkg::*;

   logic              valid_ff;
   logic              func_ff;
   logic [HALF_W-1:0] n1_ff;
   logic [HALF_W-1:0] n2_ff;
   logic [HALF_W-1:0] n1_in;

   assign n1_in = round_func(stage_in.n1, subkey) ^ stage_in.n2;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= stage_in.func;
      n1_ff   <= n1_in;
      n2_ff   <= stage_in.n1;
   end

   assign stage_out.valid = valid_ff;
   assign stage_out.func  = func_ff;
   assign stage_out.n1    = n1_ff;
   assign stage_out.n2    = n2_ff;

endmodule

[design/feistel_block_cipher_64.sv]
`timescale 1ns / 1ps
// ============================================================================
// feistel_block_cipher_64
// 32-round Feistel block cipher (GOST 28147-89 core), one round per stage.
// ============================================================================
// Each round is one registered stage between start and the rsp_valid strobe.
// Throughput: one word per cycle; busy is low except during reset.
// The receiver cannot stall, so the pipeline always advances.
// Reset clears the stage valid bits and all subkeys to zero.
module feistel_block_cipher_64 (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_func,
   input  logic [fbc_pkg::BLOCK_W-1:0]   req_block_in,
   output logic                          rsp_valid,
   output logic [fbc_pkg::BLOCK_W-1:0]   rsp_block_out,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fbc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fbc_pkg::BLOCK_W-1:0]   csr_data
);
   import fbc_pkg::*;

   fbc_keys_type  keys;
   fbc_stage_type stage [ROUNDS+1];

   assign busy = reset;

   fbc_key_regs u_key_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .keys      (keys)
   );

   assign stage[0].valid = start & ~busy;
   assign stage[0].func  = req_func;
   assign stage[0].n1    = req_block_in[BLOCK_W-1:HALF_W];
   assign stage[0].n2    = req_block_in[HALF_W-1:0];

   for (genvar g = 0; g < ROUNDS; g++) begin : g_round
      localparam logic [2:0] ENC_IDX = key_index(5'(g), FUNC_ENCRYPT);
      localparam logic [2:0] DEC_IDX = key_index(5'(g), FUNC_DECRYPT);
      logic [HALF_W-1:0] subkey;

      // Each round uses one of two fixed subkeys, picked by the word's operation.
      assign subkey = (stage[g].func == FUNC_DECRYPT) ? keys[DEC_IDX] : keys[ENC_IDX];

      fbc_round u_round (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (stage[g]),
         .subkey    (subkey),
         .stage_out (stage[g+1])
      );
   end

   // The last swap is undone by emitting N2 in the upper half.
   assign rsp_valid     = stage[ROUNDS].valid;
   assign rsp_block_out = {stage[ROUNDS].n2, stage[ROUNDS].n1};

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the 64-bit GOST Feistel cipher core.
// Blocks and subkeys are driven through the command and key ports with random
// gaps. Each returned word is compared with a cipher computed in the bench
// from its own copy of the subkeys.
// ============================================================================
module tb;

   import fbc_pkg::*;

   localparam int unsigned QUIET_LIMIT   = 1000;
   localparam int unsigned END_WAIT      = 40;
   localparam int unsigned RAND_PHASES   = 8;
   localparam int unsigned PHASE_WORDS   = 235;
   localparam int unsigned STEADY_PHASE  = 2;
   localparam int unsigned IDLE_PERCENT  = 38;
   localparam int unsigned MAX_PRINTS    = 100;

   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   localparam logic [CSR_IDX_W-1:0] KEY_REGS [4] = '{
      CSR_KEY_0_1, CSR_KEY_2_3, CSR_KEY_4_5, CSR_KEY_6_7
   };

   // Substitution rows, nibble j of the sum goes through row j.
   localparam logic [3:0] GOST_SBOX [8][16] = '{
      '{4'hF, 4'hC, 4'h2, 4'hA, 4'h6, 4'h4, 4'h5, 4'h0,
        4'h7, 4'h9, 4'hE, 4'hD, 4'h1, 4'hB, 4'h8, 4'h3},
      '{4'hB, 4'h6, 4'h3, 4'h4, 4'hC, 4'hF, 4'hE, 4'h2,
        4'h7, 4'hD, 4'h8, 4'h0, 4'h5, 4'hA, 4'h9, 4'h1},
      '{4'h1, 4'hC, 4'hB, 4'h0, 4'hF, 4'hE, 4'h6, 4'h5,
        4'hA, 4'hD, 4'h4, 4'h8, 4'h9, 4'h3, 4'h7, 4'h2},
      '{4'h1, 4'h5, 4'hE, 4'hC, 4'hA, 4'h7, 4'h0, 4'hD,
        4'h6, 4'h2, 4'hB, 4'h4, 4'h9, 4'h3, 4'hF, 4'h8},
      '{4'h0, 4'hC, 4'h8, 4'h9, 4'hD, 4'h2, 4'hA, 4'hB,
        4'h7, 4'h3, 4'h6, 4'h5, 4'h4, 4'hE, 4'hF, 4'h1},
      '{4'h8, 4'h0, 4'hF, 4'h3, 4'h2, 4'h5, 4'hE, 4'hB,
        4'h1, 4'hA, 4'h4, 4'h7, 4'hC, 4'h9, 4'hD, 4'h6},
      '{4'h3, 4'h0, 4'h6, 4'hF, 4'h1, 4'hE, 4'h9, 4'h2,
        4'hD, 4'h8, 4'hC, 4'h4, 4'hB, 4'hA, 4'h5, 4'h7},
      '{4'h1, 4'hA, 4'h6, 4'h8, 4'hF, 4'hB, 4'h0, 4'h4,
        4'hC, 4'h3, 4'h5, 4'h9, 4'h7, 4'hD, 4'h2, 4'hE}
   };

   typedef struct {
      logic        func;
      logic [63:0] block_in;
      logic [63:0] block_out;
   } cipher_job_type;

   typedef struct packed {
      logic                 is_key;
      logic [CSR_IDX_W-1:0] key_reg;
      logic                 func;
      logic [63:0]          value;
   } stim_row_type;

   // Directed words. The ciphertexts cannot be read by eye, so every word
   // goes through the bench cipher like the random ones.
   localparam stim_row_type DIRECTED [31] = '{
      // subkeys all zero after reset
      '{1'b0, CSR_KEY_0_1, FUNC_ENCRYPT, 64'h0},
      '{1'b0, CSR_KEY_0_1, FUNC_ENCRYPT, ALL_ONES},
      '{1'b0, CSR_KEY_0_1, FUNC_DECRYPT, 64'h0},
      '{1'b0, CSR_KEY_0_1, FUNC_DECRYPT, ALL_ONES},
      '{1'b0, CSR_KEY_0_1, FUNC_ENCRYPT, 64'h8000_0000_0000_0001},
      '{1'b0, CSR_KEY_0_1, FUNC_DECRYPT, 64'hAAAA_AAAA_5555_5555},
      // subkeys all ones, so the subkey addition wraps around
      '{1'b1, CSR_KEY_0_1, FUNC_ENCRYPT, ALL_ONES},
      '{1'b1, CSR_KEY_2_3, FUNC_ENCRYPT, ALL_ONES},
      '{1'b1, CSR_KEY_4_5, FUNC_ENCRYPT, ALL_ONES},
      '{1'b1, CSR_KEY_6_7, FUNC_ENCRYPT, ALL_ONES},
      '{1'b0, CSR_KEY_0_1, FUNC_ENCRYPT, 64'h0},
      '{1'b0, CSR_KEY_0_1, FUNC_ENCRYPT, ALL_ONES},
      '{1'b0, CSR_KEY_0_1, FUNC_DECRYPT, 64'h0},
      '{1'b0, CSR_KEY_0_1, FUNC_DECRYPT, ALL_ONES},
      '{1'b0, CSR_KEY_0_1, FUNC_ENCRYPT, 64'h0000_0001_FFFF_FFFE},
      // distinct subkeys, so a wrong key schedule shows up
      '{1'b1, CSR_KEY_0_1, FUNC_ENCRYPT, 64'h0123_4567_89AB_CDEF},
      '{1'b1, CSR_KEY_2_3, FUNC_ENCRYPT, 64'hFEDC_BA98_7654_3210},
      '{1'b1, CSR_KEY_4_5, FUNC_ENCRYPT, 64'h8000_0000_0000_0001},
      '{1'b1, CSR_KEY_6_7, FUNC_ENCRYPT, 64'h7FFF_FFFF_FFFF_FFFE},
      '{1'b0, CSR_KEY_0_1, FUNC_ENCRYPT, 64'hFEDC_BA98_7654_3210},
      '{1'b0, CSR_KEY_0_1, FUNC_DECRYPT, 64'hFEDC_BA98_7654_3210},
      '{1'b0, CSR_KEY_0_1, FUNC_ENCRYPT, 64'h0000_0000_FFFF_FFFF},
      '{1'b0, CSR_KEY_0_1, FUNC_DECRYPT, 64'hFFFF_FFFF_0000_0000},
      '{1'b0, CSR_KEY_0_1, FUNC_ENCRYPT, 64'h5555_5555_AAAA_AAAA},
      '{1'b0, CSR_KEY_0_1, FUNC_DECRYPT, 64'h0000_0000_0000_0001},
      '{1'b0, CSR_KEY_0_1, FUNC_ENCRYPT, 64'h8000_0000_0000_0000},
      '{1'b0, CSR_KEY_0_1, FUNC_ENCRYPT, 64'h0},
      '{1'b0, CSR_KEY_0_1, FUNC_DECRYPT, ALL_ONES},
      '{1'b0, CSR_KEY_0_1, FUNC_ENCRYPT, ALL_ONES},
      '{1'b0, CSR_KEY_0_1, FUNC_DECRYPT, 64'h0},
      '{1'b0, CSR_KEY_0_1, FUNC_ENCRYPT, 64'h0F0F_0F0F_F0F0_F0F0}
   };

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_func;
   logic [BLOCK_W-1:0]   req_block_in;
   logic                 rsp_valid;
   logic [BLOCK_W-1:0]   rsp_block_out;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [BLOCK_W-1:0]   csr_data;

   logic [HALF_W-1:0] subkeys [NUM_KEYS];
   cipher_job_type    pending_blocks [$];
   int unsigned       mismatch_cnt;
   int unsigned       quiet_cycles;
   bit                steady;

   feistel_block_cipher_64 i_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_block_in  (req_block_in),
      .rsp_valid     (rsp_valid),
      .rsp_block_out (rsp_block_out),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // 32 rounds of the Feistel network under the bench copy of the subkeys.
   function automatic logic [63:0] gost_transform(input logic dec, input logic [63:0] blk);
      logic [31:0] n1;
      logic [31:0] n2;
      logic [31:0] sum;
      logic [31:0] subst;
      logic [31:0] mixed;
      int unsigned ki;
      n1 = blk[63:32];
      n2 = blk[31:0];
      for (int unsigned r = 0; r < ROUNDS; r++) begin
         if (dec) begin
            ki = (r < 8) ? r : 7 - (r % 8);
         end else begin
            ki = (r < 24) ? (r % 8) : 7 - (r % 8);
         end
         sum = n1 + subkeys[ki];
         for (int unsigned j = 0; j < 8; j++) begin
            subst[4*j +: 4] = GOST_SBOX[j][sum[4*j +: 4]];
         end
         mixed = {subst[20:0], subst[31:21]} ^ n2;
         n2 = n1;
         n1 = mixed;
      end
      return {n2, n1};
   endfunction

   // Mostly random words, with the extremes and single set bits mixed in.
   function automatic logic [63:0] pick_word();
      logic [63:0] w;
      case ($urandom_range(9))
         0: w = 64'h0;
         1: w = ALL_ONES;
         2: w = 64'h1 << $urandom_range(63);
         default: w = {$urandom, $urandom};
      endcase
      return w;
   endfunction

   function automatic int unsigned idle_gap();
      int unsigned n;
      n = 0;
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PERCENT) n++;
      end
      return n;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_cnt < MAX_PRINTS) begin
         $display("ERROR %0t: %s got %016h expected %016h", $realtime, what, got, want);
      end
      mismatch_cnt++;
   endtask

   // Called at a falling edge; returns at a falling edge after acceptance.
   task automatic send_block(input logic f, input logic [63:0] blk);
      cipher_job_type job;
      int unsigned gap;
      gap = idle_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start        <= 1'b1;
      req_func     <= f;
      req_block_in <= blk;
      do @(posedge clock); while (busy);
      job.func      = f;
      job.block_in  = blk;
      job.block_out = gost_transform(f, blk);
      pending_blocks.push_back(job);
      @(negedge clock);
   endtask

   task automatic write_key(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] value);
      int unsigned gap;
      gap = idle_gap();
      if (gap > 0) begin
         csr_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_KEY_0_1: begin
            subkeys[0] = value[63:32];
            subkeys[1] = value[31:0];
         end
         CSR_KEY_2_3: begin
            subkeys[2] = value[63:32];
            subkeys[3] = value[31:0];
         end
         CSR_KEY_4_5: begin
            subkeys[4] = value[63:32];
            subkeys[5] = value[31:0];
         end
         CSR_KEY_6_7: begin
            subkeys[6] = value[63:32];
            subkeys[7] = value[31:0];
         end
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Drop both request lines and wait until every word has come back. Always
   // moves on by at least one falling edge so the lines are raised afresh.
   task automatic drain();
      start     <= 1'b0;
      csr_valid <= 1'b0;
      do @(negedge clock); while (pending_blocks.size() != 0);
   endtask

   always @(posedge clock) begin : check_output
      cipher_job_type job;
      if (!reset && rsp_valid) begin
         if (pending_blocks.size() == 0) begin
            report_mismatch("unexpected word", rsp_block_out, 64'h0);
         end else begin
            job = pending_blocks.pop_front();
            if (rsp_block_out !== job.block_out) begin
               report_mismatch($sformatf("%s of %016h",
                                         job.func == FUNC_DECRYPT ? "decrypt" : "encrypt",
                                         job.block_in),
                               rsp_block_out, job.block_out);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
         $display("FAIL feistel_block_cipher_64");
         $finish;
      end
   end

   initial begin
      logic was_key;
      int unsigned off;
      reset        = 1'b1;
      start        = 1'b0;
      req_func     = FUNC_ENCRYPT;
      req_block_in = '0;
      csr_valid    = 1'b0;
      csr_index    = CSR_KEY_0_1;
      csr_data     = '0;
      mismatch_cnt = 0;
      quiet_cycles = 0;
      steady       = 1'b0;
      for (int i = 0; i < NUM_KEYS; i++) subkeys[i] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      was_key = 1'b0;
      foreach (DIRECTED[i]) begin
         // Keys change only with the pipeline empty.
         if (DIRECTED[i].is_key != was_key) drain();
         was_key = DIRECTED[i].is_key;
         if (DIRECTED[i].is_key) begin
            write_key(DIRECTED[i].key_reg, DIRECTED[i].value);
         end else begin
            send_block(DIRECTED[i].func, DIRECTED[i].value);
         end
      end

      for (int unsigned p = 0; p < RAND_PHASES; p++) begin
         drain();
         steady = (p == STEADY_PHASE);
         off = $urandom_range(3);
         for (int unsigned k = 0; k < 4; k++) begin
            if (p == 0 || $urandom_range(3) != 0) begin
               write_key(KEY_REGS[(k + off) % 4], pick_word());
            end
         end
         drain();
         for (int unsigned n = 0; n < PHASE_WORDS; n++) begin
            send_block($urandom_range(1) ? FUNC_DECRYPT : FUNC_ENCRYPT, pick_word());
         end
      end

      steady = 1'b0;
      drain();
      repeat (END_WAIT) @(negedge clock);
      if (mismatch_cnt == 0) begin
         $display("PASS feistel_block_cipher_64");
      end else begin
         $display("FAIL feistel_block_cipher_64");
      end
      $finish;
   end

endmodule
